### rtl/core/pip_pkg.sv
// Package: coordinate widths, register indexes, flag bit positions and stage types.
`timescale 1ns / 1ps

package pip_pkg;

  // Coordinate widths
  localparam int COORD_BITS = 32;
  localparam int LAT_W      = COORD_BITS - 1;
  localparam int LON_W      = COORD_BITS;
  localparam int DLAT_W     = LAT_W + 1;
  localparam int DLON_W     = LON_W + 1;
  localparam int PROD_W     = DLAT_W + DLON_W;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LON_W;

  localparam logic [CFG_IDX_W-1:0] REG_POINT_LAT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_LON    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXCLUDE_MODE = 2'd2;

  // Crossing flag bit positions
  localparam int FLAG_W        = 7;
  localparam int FB_INSIDE     = 0;
  localparam int FB_LIMBO      = 1;
  localparam int FB_LIMBO_UP   = 2;
  localparam int FB_LIMBO_BEGIN = 3;
  localparam int FB_BEGIN_UP   = 4;
  localparam int FB_BEGIN_HOR  = 5;
  localparam int FB_UP         = 6;

  typedef logic [FLAG_W-1:0] flags_t;

  // One edge as it sits in the input register
  typedef struct packed {
    logic signed [LAT_W-1:0] from_lat;
    logic signed [LON_W-1:0] from_lon;
    logic signed [LAT_W-1:0] to_lat;
    logic signed [LON_W-1:0] to_lon;
    logic                    first_edge;
    logic                    last_edge;
    logic                    restart;
  } edge_t;

  // Pre-decoded edge: compares against the point and the two cross products
  typedef struct packed {
    logic                     first_edge;
    logic                     last_edge;
    logic                     restart;
    logic                     la1_eq;
    logic                     la1_lt;
    logic                     la2_eq;
    logic                     la2_lt;
    logic                     lo1_gt;
    logic                     lo2_gt;
    logic signed [PROD_W-1:0] prod_a;
    logic signed [PROD_W-1:0] prod_b;
  } stage_t;

endpackage

### rtl/core/pip_if.sv
// Interfaces: edge input channel and result output channel.
`timescale 1ns / 1ps

interface pip_edge_if import pip_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] from_lat;
  logic signed [LON_W-1:0] from_lon;
  logic signed [LAT_W-1:0] to_lat;
  logic signed [LON_W-1:0] to_lon;
  logic                    first_edge;
  logic                    last_edge;
  logic                    restart;

  modport source (
    output valid, from_lat, from_lon, to_lat, to_lon, first_edge, last_edge, restart,
    input  ready
  );
  modport sink (
    input  valid, from_lat, from_lon, to_lat, to_lon, first_edge, last_edge, restart,
    output ready
  );
endinterface

interface pip_result_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic keep_point;

  modport source (output valid, inside_res, keep_point, input ready);
  modport sink (input valid, inside_res, keep_point, output ready);
endinterface

### rtl/core/pip_edge_prep.sv
// Input register and pre-decode stage: point compares and cross products per edge.
`timescale 1ns / 1ps

module pip_edge_prep import pip_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  pip_edge_if.sink                edge_in,
  input  logic signed [LAT_W-1:0] point_lat,
  input  logic signed [LON_W-1:0] point_lon,
  output logic                    s2_valid,
  output stage_t                  s2_data,
  input  logic                    s2_ready
);

  logic                     s1_valid;
  edge_t                    s1_edge;
  logic                     ready2;
  stage_t                   stage_next;
  logic signed [DLON_W-1:0] dlon21;
  logic signed [DLON_W-1:0] dlon31;
  logic signed [DLAT_W-1:0] dlat31;
  logic signed [DLAT_W-1:0] dlat21;

  // Stall chain
  assign ready2        = !s2_valid || s2_ready;
  assign edge_in.ready = !s1_valid || ready2;

  // Hold the accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (edge_in.ready) begin
      s1_valid <= edge_in.valid;
    end
    if (edge_in.valid && edge_in.ready) begin
      s1_edge.from_lat   <= edge_in.from_lat;
      s1_edge.from_lon   <= edge_in.from_lon;
      s1_edge.to_lat     <= edge_in.to_lat;
      s1_edge.to_lon     <= edge_in.to_lon;
      s1_edge.first_edge <= edge_in.first_edge;
      s1_edge.last_edge  <= edge_in.last_edge;
      s1_edge.restart    <= edge_in.restart;
    end
  end

  // Differences, sign extended by one bit so they cannot overflow
  assign dlon21 = {s1_edge.to_lon[LON_W-1], s1_edge.to_lon}
                - {s1_edge.from_lon[LON_W-1], s1_edge.from_lon};
  assign dlon31 = {point_lon[LON_W-1], point_lon}
                - {s1_edge.from_lon[LON_W-1], s1_edge.from_lon};
  assign dlat31 = {point_lat[LAT_W-1], point_lat}
                - {s1_edge.from_lat[LAT_W-1], s1_edge.from_lat};
  assign dlat21 = {s1_edge.to_lat[LAT_W-1], s1_edge.to_lat}
                - {s1_edge.from_lat[LAT_W-1], s1_edge.from_lat};

  // Compare the edge ends against the point, form both cross products
  always_comb begin
    stage_next.first_edge = s1_edge.first_edge;
    stage_next.last_edge  = s1_edge.last_edge;
    stage_next.restart    = s1_edge.restart;
    stage_next.la1_eq     = s1_edge.from_lat == point_lat;
    stage_next.la1_lt     = s1_edge.from_lat < point_lat;
    stage_next.la2_eq     = s1_edge.to_lat == point_lat;
    stage_next.la2_lt     = s1_edge.to_lat < point_lat;
    stage_next.lo1_gt     = s1_edge.from_lon > point_lon;
    stage_next.lo2_gt     = s1_edge.to_lon > point_lon;
    stage_next.prod_a     = dlon21 * dlat31;
    stage_next.prod_b     = dlon31 * dlat21;
  end

  // Advance into the pre-decode register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (ready2) begin
      s2_valid <= s1_valid;
    end
    if (s1_valid && ready2) begin
      s2_data <= stage_next;
    end
  end

endmodule

### rtl/core/pip_flag_update.sv
// Crossing flag state, per-edge flag update and result register.
`timescale 1ns / 1ps

module pip_flag_update import pip_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s2_valid,
  input  stage_t    s2_data,
  output logic      s2_ready,
  input  logic      exclude_mode,
  pip_result_if.source res_out
);

  flags_t flags;
  flags_t flags_next;
  logic   adv;
  logic   crossing;
  logic   east;

  // Toggle inside when the opening vertex direction matches, then drop the begin marks
  function automatic flags_t close_begin(input flags_t s_in, input logic want_up);
    flags_t s;
    s = s_in;
    if (s[FB_BEGIN_UP] == want_up) begin
      s[FB_INSIDE] = ~s[FB_INSIDE];
    end
    s[FB_LIMBO_BEGIN] = 1'b0;
    s[FB_BEGIN_UP]    = 1'b0;
    return s;
  endfunction

  assign s2_ready = !res_out.valid || res_out.ready;
  assign adv      = s2_valid && s2_ready;

  // Strict crossing of the point latitude, and whether it passes east of the point
  assign crossing = !s2_data.la1_eq && !s2_data.la2_eq && (s2_data.la1_lt != s2_data.la2_lt);
  always_comb begin
    if (s2_data.lo1_gt && s2_data.lo2_gt) begin
      east = 1'b1;
    end else if (!s2_data.lo1_gt && !s2_data.lo2_gt) begin
      east = 1'b0;
    end else if (s2_data.la1_lt) begin
      east = s2_data.prod_a > s2_data.prod_b;
    end else begin
      east = s2_data.prod_a < s2_data.prod_b;
    end
  end

  // Flag update for one edge
  always_comb begin
    flags_t s;
    s = s2_data.restart ? '0 : flags;
    if (s2_data.la1_eq) begin
      if (s2_data.la2_lt) begin
        // edge leaves the ray downward
        if (s[FB_LIMBO]) begin
          if (s[FB_LIMBO_UP]) begin
            s[FB_INSIDE] = ~s[FB_INSIDE];
          end
          s[FB_LIMBO]    = 1'b0;
          s[FB_LIMBO_UP] = 1'b0;
        end else if (s[FB_LIMBO_BEGIN]) begin
          if (s[FB_BEGIN_HOR]) begin
            s[FB_BEGIN_HOR] = 1'b0;
          end else if (s2_data.last_edge) begin
            s = close_begin(s, 1'b1);
          end
        end else if (s2_data.first_edge && s2_data.lo1_gt) begin
          s[FB_LIMBO_BEGIN] = 1'b1;
        end
      end else if (s2_data.la2_eq) begin
        // horizontal run on the ray
        if (s2_data.first_edge && (s2_data.lo1_gt || s2_data.lo2_gt)) begin
          s[FB_LIMBO_BEGIN] = 1'b1;
          s[FB_BEGIN_HOR]   = 1'b1;
        end else if (s2_data.last_edge && s[FB_LIMBO_BEGIN] && s[FB_LIMBO]) begin
          if (s[FB_LIMBO_UP] != s[FB_BEGIN_UP]) begin
            s[FB_INSIDE] = ~s[FB_INSIDE];
          end
          s[FB_LIMBO]       = 1'b0;
          s[FB_LIMBO_UP]    = 1'b0;
          s[FB_LIMBO_BEGIN] = 1'b0;
          s[FB_BEGIN_UP]    = 1'b0;
        end else if (!s[FB_LIMBO] && !s2_data.lo1_gt && s2_data.lo2_gt) begin
          if (s[FB_UP]) begin
            s[FB_LIMBO_UP] = 1'b1;
          end
          s[FB_LIMBO] = 1'b1;
        end
      end else begin
        // edge leaves the ray upward
        if (s[FB_LIMBO]) begin
          if (!s[FB_LIMBO_UP]) begin
            s[FB_INSIDE] = ~s[FB_INSIDE];
          end
          s[FB_LIMBO]    = 1'b0;
          s[FB_LIMBO_UP] = 1'b0;
        end else if (s[FB_LIMBO_BEGIN]) begin
          if (s[FB_BEGIN_HOR]) begin
            s[FB_BEGIN_HOR] = 1'b0;
            s[FB_BEGIN_UP]  = 1'b1;
          end else if (s2_data.last_edge) begin
            s = close_begin(s, 1'b0);
          end
        end else if (s2_data.first_edge && s2_data.lo1_gt) begin
          s[FB_LIMBO_BEGIN] = 1'b1;
          s[FB_BEGIN_UP]    = 1'b1;
        end
      end
      s[FB_UP] = 1'b0;
    end else if (s2_data.la2_eq) begin
      // edge arrives on the ray
      if (s2_data.la1_lt) begin
        if (s2_data.last_edge) begin
          s = close_begin(s, 1'b1);
        end else if (s2_data.lo2_gt) begin
          s[FB_LIMBO] = 1'b1;
        end
      end else begin
        if (s2_data.last_edge) begin
          s = close_begin(s, 1'b0);
        end else if (s2_data.lo2_gt) begin
          s[FB_LIMBO]    = 1'b1;
          s[FB_LIMBO_UP] = 1'b1;
        end else begin
          s[FB_UP] = 1'b1;
        end
      end
    end else if (crossing && east) begin
      s[FB_INSIDE] = ~s[FB_INSIDE];
    end
    flags_next = s;
  end

  // Commit flags and load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      flags         <= '0;
      res_out.valid <= 1'b0;
    end else begin
      if (adv) begin
        flags <= flags_next;
      end
      if (s2_ready) begin
        res_out.valid <= s2_valid;
      end
    end
    if (adv) begin
      res_out.inside_res <= flags_next[FB_INSIDE];
      res_out.keep_point <= flags_next[FB_INSIDE] ^ exclude_mode;
    end
  end

`ifndef SYNTHESIS
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !res_out.valid)
    else $error("result valid right after reset");
  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(flags))
    else $error("crossing flags changed without an advancing edge");
  a_result_tracks_flags: assert property (@(posedge clk) disable iff (rst)
    adv |=> (res_out.valid && res_out.inside_res == flags[FB_INSIDE]))
    else $error("result does not match committed inside flag");
  a_keep_relation: assert property (@(posedge clk) disable iff (rst)
    res_out.valid |-> (res_out.keep_point == (res_out.inside_res ^ exclude_mode)))
    else $error("keep bit inconsistent with inside bit and exclude mode");
`endif

endmodule

### rtl/core/point_in_polygon_edge_test_core.sv
// An accepted edge moves through the input register, the pre-decode register
// and the result register. Throughput: one edge per cycle when the result side
// does not stall; these form three stages, with the flag update in the last one.
// Reset (synchronous, active high) clears all valids, the crossing flags and
// the point and exclude-mode registers.
`timescale 1ns / 1ps

module point_in_polygon_edge_test_core import pip_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  pip_edge_if.sink              edge_in,
  pip_result_if.source          res_out
);

  logic signed [LAT_W-1:0] point_lat;
  logic signed [LON_W-1:0] point_lon;
  logic                    exclude_mode;
  logic                    s2_valid;
  stage_t                  s2_data;
  logic                    s2_ready;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      point_lat    <= '0;
      point_lon    <= '0;
      exclude_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_POINT_LAT:    point_lat    <= cfg_wr_data[LAT_W-1:0];
        REG_POINT_LON:    point_lon    <= cfg_wr_data[LON_W-1:0];
        REG_EXCLUDE_MODE: exclude_mode <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  pip_edge_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .edge_in   (edge_in),
    .point_lat (point_lat),
    .point_lon (point_lon),
    .s2_valid  (s2_valid),
    .s2_data   (s2_data),
    .s2_ready  (s2_ready)
  );

  pip_flag_update u_flags (
    .clk          (clk),
    .rst          (rst),
    .s2_valid     (s2_valid),
    .s2_data      (s2_data),
    .s2_ready     (s2_ready),
    .exclude_mode (exclude_mode),
    .res_out      (res_out)
  );

endmodule

### tb/tb_point_in_polygon_edge_test_core.sv
// Testbench: streams polygon edges into point_in_polygon_edge_test_core and checks each verdict.
`timescale 1ns / 1ps

module tb_point_in_polygon_edge_test_core;
  import pip_pkg::*;

  localparam int TIMEOUT_NS     = 10_000_000;
  localparam int RX_HOLD_CYCLES = 120;
  localparam int DRAIN_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 6;

  // Unmapped register index; writes to it are dropped by the block
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic inside_res;
    logic keep_point;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_wr_en   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

  pip_edge_if   edge_bus ();
  pip_result_if res_bus ();

  point_in_polygon_edge_test_core uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .edge_in     (edge_bus),
    .res_out     (res_bus)
  );

  // Shadow of the configured point and the crossing flags
  longint   pt_lat     = 0;
  longint   pt_lon     = 0;
  bit       exclude_on = 1'b0;
  flags_t   ray_flags  = '0;

  verdict_t pending_verdicts[$];
  int       items_sent    = 0;
  int       results_seen  = 0;
  int       error_count   = 0;
  bit       tx_idle       = 1'b1;
  bit       rx_idle       = 1'b1;
  bit       rx_hold_req   = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch at result %0d: %s", $time, results_seen, msg);
    error_count++;
  endtask

  // Clear the begin-limbo marks, toggling inside when the ring closes in the
  // same direction the begin run was entered
  function automatic flags_t seal_begin(input flags_t s, input bit want_up);
    if (s[FB_BEGIN_UP] == want_up) s[FB_INSIDE] = ~s[FB_INSIDE];
    s[FB_LIMBO_BEGIN] = 1'b0;
    s[FB_BEGIN_UP]    = 1'b0;
    return s;
  endfunction

  // Advance the crossing flags by one edge against the configured point
  function automatic flags_t crossing_step(input flags_t s, input longint la1, input longint lo1,
                                           input longint la2, input longint lo2,
                                           input bit first, input bit last);
    logic signed [PROD_W+2:0] d_lo, d_la, d_lo3, d_lat, cross_lhs, cross_rhs;
    if (la1 == pt_lat) begin
      if (la2 < pt_lat) begin
        if (s[FB_LIMBO]) begin
          if (s[FB_LIMBO_UP]) s[FB_INSIDE] = ~s[FB_INSIDE];
          s[FB_LIMBO]    = 1'b0;
          s[FB_LIMBO_UP] = 1'b0;
        end else if (s[FB_LIMBO_BEGIN]) begin
          if (s[FB_BEGIN_HOR]) s[FB_BEGIN_HOR] = 1'b0;
          else if (last) s = seal_begin(s, 1'b1);
        end else if (first && lo1 > pt_lon) begin
          s[FB_LIMBO_BEGIN] = 1'b1;
        end
      end else if (la2 == pt_lat) begin
        if (first && (lo1 > pt_lon || lo2 > pt_lon)) begin
          s[FB_LIMBO_BEGIN] = 1'b1;
          s[FB_BEGIN_HOR]   = 1'b1;
        end else if (last && s[FB_LIMBO_BEGIN] && s[FB_LIMBO]) begin
          if (s[FB_LIMBO_UP] != s[FB_BEGIN_UP]) s[FB_INSIDE] = ~s[FB_INSIDE];
          s[FB_LIMBO]       = 1'b0;
          s[FB_LIMBO_UP]    = 1'b0;
          s[FB_LIMBO_BEGIN] = 1'b0;
          s[FB_BEGIN_UP]    = 1'b0;
        end else if (!s[FB_LIMBO] && lo1 <= pt_lon && lo2 > pt_lon) begin
          if (s[FB_UP]) s[FB_LIMBO_UP] = 1'b1;
          s[FB_LIMBO] = 1'b1;
        end
      end else begin
        if (s[FB_LIMBO]) begin
          if (!s[FB_LIMBO_UP]) s[FB_INSIDE] = ~s[FB_INSIDE];
          s[FB_LIMBO]    = 1'b0;
          s[FB_LIMBO_UP] = 1'b0;
        end else if (s[FB_LIMBO_BEGIN]) begin
          if (s[FB_BEGIN_HOR]) begin
            s[FB_BEGIN_HOR] = 1'b0;
            s[FB_BEGIN_UP]  = 1'b1;
          end else if (last) begin
            s = seal_begin(s, 1'b0);
          end
        end else if (first && lo1 > pt_lon) begin
          s[FB_LIMBO_BEGIN] = 1'b1;
          s[FB_BEGIN_UP]    = 1'b1;
        end
      end
      s[FB_UP] = 1'b0;
    end else if (la2 == pt_lat) begin
      if (la1 < pt_lat) begin
        if (last) s = seal_begin(s, 1'b1);
        else if (lo2 > pt_lon) s[FB_LIMBO] = 1'b1;
      end else begin
        if (last) begin
          s = seal_begin(s, 1'b0);
        end else if (lo2 > pt_lon) begin
          s[FB_LIMBO]    = 1'b1;
          s[FB_LIMBO_UP] = 1'b1;
        end else begin
          s[FB_UP] = 1'b1;
        end
      end
    end else if ((la1 > pt_lat && la2 < pt_lat) || (la1 < pt_lat && la2 > pt_lat)) begin
      if (lo1 > pt_lon && lo2 > pt_lon) begin
        s[FB_INSIDE] = ~s[FB_INSIDE];
      end else if (!(lo1 <= pt_lon && lo2 <= pt_lon)) begin
        // Compare the ray crossing against the point by cross multiplication
        d_lo      = lo2 - lo1;
        d_la      = pt_lat - la1;
        d_lo3     = pt_lon - lo1;
        d_lat     = la2 - la1;
        cross_lhs = d_lo * d_la;
        cross_rhs = d_lo3 * d_lat;
        if ((d_lat > 0 && cross_lhs > cross_rhs) || (d_lat < 0 && cross_lhs < cross_rhs))
          s[FB_INSIDE] = ~s[FB_INSIDE];
      end
    end
    return s;
  endfunction

  function automatic edge_t make_item(input longint la1, input longint lo1,
                                      input longint la2, input longint lo2,
                                      input bit first, input bit last, input bit restart);
    edge_t e;
    e.from_lat   = la1[LAT_W-1:0];
    e.from_lon   = lo1[LON_W-1:0];
    e.to_lat     = la2[LAT_W-1:0];
    e.to_lon     = lo2[LON_W-1:0];
    e.first_edge = first;
    e.last_edge  = last;
    e.restart    = restart;
    return e;
  endfunction

  // Vertex on a grid around the point, often on its latitude, now and then any pattern
  function automatic void pick_vertex(input longint step, output longint la, output longint lo);
    logic signed [LAT_W-1:0] raw_lat;
    logic signed [LON_W-1:0] raw_lon;
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      raw_lat = LAT_W'($urandom());
      raw_lon = $urandom();
      la = raw_lat;
      lo = raw_lon;
    end else begin
      la = (sel < 7) ? pt_lat : pt_lat + (longint'($urandom_range(0, 4)) - 2) * step;
      lo = pt_lon + (longint'($urandom_range(0, 6)) - 3) * step;
    end
  endfunction

  function automatic edge_t noise_item();
    edge_t e;
    logic [159:0] raw_bits;
    longint la1, lo1, la2, lo2;
    if ($urandom_range(0, 1) == 0) begin
      raw_bits = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      e = raw_bits[$bits(edge_t)-1:0];
    end else begin
      pick_vertex(longint'($urandom_range(1, 300)), la1, lo1);
      pick_vertex(longint'($urandom_range(1, 300)), la2, lo2);
      e = make_item(la1, lo1, la2, lo2, 1'($urandom()), 1'($urandom()), 1'($urandom()));
    end
    return e;
  endfunction

  // Offer one edge, wait for the transaction, then record its verdict
  task automatic send_edge(input edge_t e);
    int unsigned gap;
    verdict_t v;
    gap = tx_idle ? $urandom_range(0, 17) : 0;
    @(negedge clk);
    if (gap != 0) begin
      edge_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    edge_bus.from_lat   = e.from_lat;
    edge_bus.from_lon   = e.from_lon;
    edge_bus.to_lat     = e.to_lat;
    edge_bus.to_lon     = e.to_lon;
    edge_bus.first_edge = e.first_edge;
    edge_bus.last_edge  = e.last_edge;
    edge_bus.restart    = e.restart;
    edge_bus.valid      = 1'b1;
    do @(posedge clk); while (edge_bus.ready !== 1'b1);
    if (e.restart) ray_flags = '0;
    ray_flags = crossing_step(ray_flags,
                              longint'($signed(e.from_lat)), longint'($signed(e.from_lon)),
                              longint'($signed(e.to_lat)), longint'($signed(e.to_lon)),
                              e.first_edge, e.last_edge);
    v.inside_res = ray_flags[FB_INSIDE];
    v.keep_point = ray_flags[FB_INSIDE] ^ exclude_on;
    pending_verdicts.push_back(v);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    logic signed [LAT_W-1:0] lat_bits;
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_index   = idx;
    cfg_wr_data = data;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      REG_POINT_LAT: begin
        lat_bits = data[LAT_W-1:0];
        pt_lat   = lat_bits;
      end
      REG_POINT_LON:    pt_lon = longint'($signed(data));
      REG_EXCLUDE_MODE: exclude_on = data[0];
      default: ;
    endcase
  endtask

  task automatic set_point(input longint lat, input longint lon, input bit ex);
    write_reg(REG_POINT_LAT, lat[CFG_DATA_W-1:0]);
    write_reg(REG_POINT_LON, lon[CFG_DATA_W-1:0]);
    write_reg(REG_EXCLUDE_MODE, {$urandom() & 32'hFFFF_FFFE} | ex);
    write_reg(REG_SPARE, $urandom());
  endtask

  // Drop valid and wait until every pending verdict has come back or DRAIN_LIMIT runs out
  task automatic drain_verdicts();
    int waited;
    waited = 0;
    @(negedge clk);
    edge_bus.valid = 1'b0;
    while (pending_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Send one ring; a few are cut short or carry scrambled ring marks
  task automatic send_ring(input bit fresh);
    longint vla[8], vlo[8];
    longint step;
    int n, count, shape, j;
    bit f, l;
    step  = ($urandom_range(0, 3) == 0) ? 1 : longint'($urandom_range(1, 5000));
    n     = $urandom_range(3, 8);
    shape = $urandom_range(0, 9);
    for (int i = 0; i < n; i++) pick_vertex(step, vla[i], vlo[i]);
    count = (shape == 0) ? $urandom_range(1, n - 1) : n;
    for (int i = 0; i < count; i++) begin
      j = (i + 1) % n;
      f = (i == 0);
      l = (i == n - 1);
      if (shape == 1) begin
        f = 1'($urandom_range(0, 1));
        l = 1'($urandom_range(0, 1));
      end
      send_edge(make_item(vla[i], vlo[i], vla[j], vlo[j], f, l, fresh && i == 0));
    end
  endtask

  task automatic run_rings(input int target, input int noise_pct);
    int start;
    start = items_sent;
    while (items_sent - start < target) begin
      if ($urandom_range(0, 99) < noise_pct) send_edge(noise_item());
      else send_ring($urandom_range(0, 2) == 0);
    end
  endtask

  // Hand-built rings: vertices and horizontal runs on the ray, exact hits, extremes
  task automatic test_directed_shapes();
    set_point(0, 0, 1'b0);
    // square around the point
    send_edge(make_item(-10, -10, -10, 10, 1, 0, 1));
    send_edge(make_item(-10, 10, 10, 10, 0, 0, 0));
    send_edge(make_item(10, 10, 10, -10, 0, 0, 0));
    send_edge(make_item(10, -10, -10, -10, 0, 1, 0));
    // diamond with vertices on the ray, ring starts on one
    send_edge(make_item(0, 10, 10, 0, 1, 0, 1));
    send_edge(make_item(10, 0, 0, -10, 0, 0, 0));
    send_edge(make_item(0, -10, -10, 0, 0, 0, 0));
    send_edge(make_item(-10, 0, 0, 10, 0, 1, 0));
    // horizontal run on the ray in mid ring
    send_edge(make_item(-10, -10, 0, 5, 1, 0, 1));
    send_edge(make_item(0, 5, 0, 15, 0, 0, 0));
    send_edge(make_item(0, 15, 10, 5, 0, 0, 0));
    send_edge(make_item(10, 5, -10, -10, 0, 1, 0));
    // ring that opens with a horizontal run on the ray
    send_edge(make_item(0, 5, 0, 15, 1, 0, 1));
    send_edge(make_item(0, 15, 10, 15, 0, 0, 0));
    send_edge(make_item(10, 15, -10, -10, 0, 0, 0));
    send_edge(make_item(-10, -10, 0, 5, 0, 1, 0));
    // horizontal off the ray with both ring marks, then exact and descending diagonals
    send_edge(make_item(5, -5, 5, 5, 1, 1, 1));
    send_edge(make_item(-10, -10, 10, 10, 0, 0, 0));
    send_edge(make_item(10, 30, -10, -10, 0, 0, 0));
    // range extremes
    send_edge(make_item(900000000, -1800000000, -900000000, 1800000000, 0, 0, 1));
    send_edge(make_item(-900000000, 1800000000, 900000000, 1800000000, 0, 1, 0));
    // patterns beyond the legal range
    send_edge(make_item(1073741823, 2147483647, -1073741824, -64'sd2147483648, 1, 0, 1));
    send_edge(make_item(-1073741824, 2147483647, 1073741823, -64'sd2147483648, 0, 1, 0));
    send_edge(make_item(0, -10, 0, -20, 0, 1, 1));
    drain_verdicts();
  endtask

  // Random rings around points at and beyond the range limits
  task automatic test_point_extremes();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    set_point(900000000, 1800000000, 1'b1);
    run_rings(280, 10);
    drain_verdicts();
    tx_idle = 1'b0;
    set_point(-900000000, -1800000000, 1'b0);
    run_rings(280, 10);
    drain_verdicts();
    tx_idle = 1'b1;
    set_point(-1073741824, -64'sd2147483648, 1'b1);
    run_rings(140, 15);
    drain_verdicts();
    set_point(1073741823, 2147483647, 1'b0);
    run_rings(140, 15);
    drain_verdicts();
  endtask

  task automatic test_random_points();
    tx_idle = 1'b1;
    rx_idle = 1'b0;
    set_point(longint'($urandom_range(0, 1800000000)) - 900000000,
              longint'($urandom_range(0, 32'd3600000000)) - 1800000000, 1'b1);
    run_rings(280, 10);
    drain_verdicts();
    rx_idle = 1'b1;
    set_point(longint'($urandom_range(0, 1800000000)) - 900000000,
              longint'($urandom_range(0, 32'd3600000000)) - 1800000000, 1'b0);
    run_rings(280, 30);
    drain_verdicts();
  endtask

  // Hold the result side off while edges keep coming so the pipeline backs up
  task automatic test_backpressure();
    tx_idle     = 1'b0;
    rx_idle     = 1'b1;
    rx_hold_req = 1'b1;
    run_rings(60, 10);
    drain_verdicts();
  endtask

  // Pause the sender until all verdicts are back, several times over
  task automatic test_drain_pause();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (4) begin
      run_rings(20, 0);
      drain_verdicts();
    end
  endtask

  task automatic test_no_idle_burst();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    run_rings(100, 10);
    drain_verdicts();
  endtask

  // Result side: random stalls, plus one long hold when requested
  initial begin : result_sink
    int unsigned stall;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        res_bus.ready = 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        rx_hold_req = 1'b0;
      end
      stall = rx_idle ? $urandom_range(0, 17) : 0;
      if (stall != 0) begin
        res_bus.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_bus.ready = 1'b1;
      do @(posedge clk); while (res_bus.valid !== 1'b1);
    end
  end

  // Compare each result transaction with the oldest pending verdict
  always @(posedge clk) begin : verdict_check
    verdict_t want;
    if (!rst && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result arrived with no verdict pending");
      end else begin
        want = pending_verdicts.pop_front();
        if (res_bus.inside_res !== want.inside_res)
          report_mismatch($sformatf("inside_res got %b want %b",
                                    res_bus.inside_res, want.inside_res));
        if (res_bus.keep_point !== want.keep_point)
          report_mismatch($sformatf("keep_point got %b want %b",
                                    res_bus.keep_point, want.keep_point));
      end
      results_seen++;
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    edge_bus.valid      = 1'b0;
    edge_bus.from_lat   = '0;
    edge_bus.from_lon   = '0;
    edge_bus.to_lat     = '0;
    edge_bus.to_lon     = '0;
    edge_bus.first_edge = 1'b0;
    edge_bus.last_edge  = 1'b0;
    edge_bus.restart    = 1'b0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    test_directed_shapes();
    test_point_extremes();
    test_random_points();
    test_backpressure();
    test_drain_pause();
    test_no_idle_burst();

    drain_verdicts();
    if (pending_verdicts.size() != 0)
      report_mismatch($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/pip_pkg.sv
rtl/core/pip_if.sv
rtl/core/pip_edge_prep.sv
rtl/core/pip_flag_update.sv
rtl/core/point_in_polygon_edge_test_core.sv
tb/tb_point_in_polygon_edge_test_core.sv
